### hw/rtl/serial_line_input_queue_assert.svh
// Assertion macros used by the checker file of the line input queue.
`ifndef SERIAL_LINE_INPUT_QUEUE_ASSERT_SVH
`define SERIAL_LINE_INPUT_QUEUE_ASSERT_SVH

// Same-cycle implication, reset disables the check.
`define SLIQ_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset disables the check.
`define SLIQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sliq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliq_pkg
// Types and constants of the serial line input queue.
// ---------------------------------------------------------------------------
package sliq_pkg;

  localparam int IDX_W  = 7;
  localparam int PEND_W = 3;

  typedef enum logic [1:0] {
    OP_RECEIVE = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  localparam logic [7:0] ERASE_BYTE     = 8'h7f;
  localparam logic [7:0] NEWLINE_BYTE   = 8'h0a;
  localparam logic [7:0] BACKSPACE_BYTE = 8'h08;
  localparam logic [7:0] SPACE_BYTE     = 8'h20;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [6:0] char_index;
  } command_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       status;
    logic [2:0] lines_pending;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_ERASE_SP,
    ST_ERASE_BS
  } seq_state_t;

endpackage

### hw/rtl/sliq_line_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliq_line_mem
// Single-port character store, one access per cycle, registered read data.
// ---------------------------------------------------------------------------
module sliq_line_mem #(
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hw/rtl/sliq_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliq_seq
// Command sequencer: slot ring pointers, line lengths, memory access and
// result register.
// ---------------------------------------------------------------------------
module sliq_seq #(
  parameter int LINE_SLOTS = 4,
  parameter int LINE_CHARS = 127,
  parameter int ADDR_W     = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sliq_pkg::command_t  command,
  input  logic                echo_en,
  output logic                mem_wr,
  output logic                mem_rd,
  output logic [ADDR_W-1:0]   mem_addr,
  output logic [7:0]          mem_wdata,
  input  logic [7:0]          mem_rdata,
  output logic                result_strobe,
  output sliq_pkg::result_t   result
);
  import sliq_pkg::*;

  localparam int SW = $clog2(LINE_SLOTS);
  localparam int RW = $clog2(LINE_SLOTS + 1);
  localparam int PW = ADDR_W - SW;
  localparam int LW = $clog2(LINE_CHARS + 1);

  seq_state_t state, state_next;
  command_t   item;
  logic [SW-1:0] head, head_next;
  logic [RW-1:0] ready, ready_next;
  logic [LW-1:0] wpos, wpos_next;
  logic [LW-1:0] lens [LINE_SLOTS];
  logic          len_we;
  logic          hit, hit_next;
  logic          strobe_next;
  result_t       res_next;

  logic [SW:0]        tail_sum;
  logic [SW-1:0]      tail;
  logic [SW-1:0]      head_inc;
  logic               full;
  logic               empty;
  logic               erase_go;
  logic               read_go;
  logic [PW+IDX_W-1:0] idx_ext;
  logic [LW+IDX_W-1:0] idx_cmp;
  logic [LW+IDX_W-1:0] len_cmp;
  logic               in_range;

  function automatic logic [PEND_W-1:0] pend(input logic [RW-1:0] r);
    logic [RW+PEND_W-1:0] w;
    w = {{PEND_W{1'b0}}, r};
    return w[PEND_W-1:0];
  endfunction

  function automatic result_t make_res(input kind_t k, input logic [7:0] d, input logic s,
                                       input logic [PEND_W-1:0] p, input logic l);
    result_t r;
    r.kind          = k;
    r.data          = d;
    r.status        = s;
    r.lines_pending = p;
    r.last          = l;
    return r;
  endfunction

  assign busy = (state != ST_IDLE);

  // Ring arithmetic and shared decode of the latched command.
  always_comb begin
    tail_sum = (SW+1)'(head) + (SW+1)'(ready);
    if (tail_sum >= (SW+1)'(LINE_SLOTS)) begin
      tail_sum = tail_sum - (SW+1)'(LINE_SLOTS);
    end
    tail     = tail_sum[SW-1:0];
    head_inc = (head == SW'(LINE_SLOTS - 1)) ? '0 : head + SW'(1);
    full     = (ready == RW'(LINE_SLOTS));
    empty    = (ready == '0);
    erase_go = (op_t'(item.operation) == OP_RECEIVE) && !full &&
               (item.rx_byte == ERASE_BYTE) && (wpos != '0);
    read_go  = (op_t'(item.operation) == OP_READ) && !empty;
    idx_ext  = {{PW{1'b0}}, item.char_index};
    idx_cmp  = {{LW{1'b0}}, item.char_index};
    len_cmp  = {{IDX_W{1'b0}}, lens[head]};
    in_range = (idx_cmp < len_cmp) && (idx_cmp < (LW+IDX_W)'(LINE_CHARS));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (erase_go && echo_en) begin
          state_next = ST_ERASE_SP;
        end else if (read_go) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ERASE_SP: state_next = ST_ERASE_BS;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    head_next   = head;
    ready_next  = ready;
    wpos_next   = wpos;
    len_we      = 1'b0;
    hit_next    = hit;
    mem_wr      = 1'b0;
    mem_rd      = 1'b0;
    mem_addr    = {tail, wpos[PW-1:0]};
    mem_wdata   = item.rx_byte;
    strobe_next = 1'b0;
    res_next    = make_res(KIND_ECHO, BACKSPACE_BYTE, STATUS_DONE, pend(ready), 1'b1);
    case (state)
      ST_EXEC: begin
        case (op_t'(item.operation))
          OP_RECEIVE: begin
            if (!full) begin
              if (item.rx_byte == ERASE_BYTE) begin
                if (erase_go) begin
                  wpos_next   = wpos - LW'(1);
                  strobe_next = echo_en;
                  res_next    = make_res(KIND_ECHO, BACKSPACE_BYTE, STATUS_DONE,
                                         pend(ready), 1'b0);
                end
              end else if (item.rx_byte == NEWLINE_BYTE) begin
                len_we      = 1'b1;
                ready_next  = ready + RW'(1);
                wpos_next   = '0;
                strobe_next = echo_en;
                res_next    = make_res(KIND_ECHO, NEWLINE_BYTE, STATUS_DONE,
                                       pend(ready + RW'(1)), 1'b1);
              end else if (wpos < LW'(LINE_CHARS)) begin
                mem_wr      = 1'b1;
                wpos_next   = wpos + LW'(1);
                strobe_next = echo_en;
                res_next    = make_res(KIND_ECHO, item.rx_byte, STATUS_DONE,
                                       pend(ready), 1'b1);
              end
            end
          end
          OP_READ: begin
            if (empty) begin
              strobe_next = 1'b1;
              res_next    = make_res(KIND_READ, 8'd0, STATUS_EMPTY, pend(ready), 1'b1);
            end else begin
              // Data comes back in the next cycle, in the read state; busy stays high meanwhile.
              mem_rd   = 1'b1;
              mem_addr = {head, idx_ext[PW-1:0]};
              hit_next = in_range;
            end
          end
          OP_RELEASE: begin
            strobe_next = 1'b1;
            if (empty) begin
              res_next = make_res(KIND_RELEASE, 8'd0, STATUS_EMPTY, pend(ready), 1'b1);
            end else begin
              head_next  = head_inc;
              ready_next = ready - RW'(1);
              res_next   = make_res(KIND_RELEASE, 8'd0, STATUS_DONE,
                                    pend(ready - RW'(1)), 1'b1);
            end
          end
          default: ;
        endcase
      end
      ST_READ: begin
        strobe_next = 1'b1;
        res_next    = make_res(KIND_READ, hit ? mem_rdata : 8'd0, STATUS_DONE,
                               pend(ready), 1'b1);
      end
      ST_ERASE_SP: begin
        strobe_next = 1'b1;
        res_next    = make_res(KIND_ECHO, SPACE_BYTE, STATUS_DONE, pend(ready), 1'b0);
      end
      ST_ERASE_BS: begin
        strobe_next = 1'b1;
        res_next    = make_res(KIND_ECHO, BACKSPACE_BYTE, STATUS_DONE, pend(ready), 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      ready         <= '0;
      wpos          <= '0;
      result_strobe <= 1'b0;
      for (int i = 0; i < LINE_SLOTS; i++) begin
        lens[i] <= '0;
      end
    end else begin
      state         <= state_next;
      head          <= head_next;
      ready         <= ready_next;
      wpos          <= wpos_next;
      result_strobe <= strobe_next;
      if (len_we) begin
        lens[tail] <= wpos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= command;
    end
    hit    <= hit_next;
    result <= res_next;
  end

endmodule

### hw/rtl/serial_line_input_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_line_input_queue
// Serial console line buffer: assembles received bytes into a ring of line
// slots with echo and erase, and serves reads and releases of the oldest line.
// ---------------------------------------------------------------------------
//  channel   ports                    transfer
//  command   start, busy, command     start high while busy low
//  config    cfg_write, cfg_data      cfg_write high
//  result    result_strobe, result    one cycle per result, no back-pressure
//
// An accepted command passes the execute state, then the read state for a
// read (the character store's registered read port) or the erase space and
// erase backspace states for an erase echo. Each result is registered and shows
// in the cycle after it is formed; the last shows as busy drops, when the next command can be taken.
// Reset clears the ring pointers, line lengths and fill position and sets
// echo on; the character store is not cleared.
// ---------------------------------------------------------------------------
module serial_line_input_queue #(
  parameter int LINE_SLOTS = 4,
  parameter int LINE_CHARS = 127
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sliq_pkg::command_t command,
  input  logic               cfg_write,
  input  logic               cfg_data,
  output logic               result_strobe,
  output sliq_pkg::result_t  result
);
  import sliq_pkg::*;

  localparam int ADDR_W = $clog2(LINE_SLOTS) + $clog2(LINE_CHARS);

  logic              echo_en;
  logic              mem_wr;
  logic              mem_rd;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_en <= 1'b1;
    end else if (cfg_write) begin
      echo_en <= cfg_data;
    end
  end

  sliq_seq #(
    .LINE_SLOTS(LINE_SLOTS),
    .LINE_CHARS(LINE_CHARS),
    .ADDR_W    (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .echo_en      (echo_en),
    .mem_wr       (mem_wr),
    .mem_rd       (mem_rd),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata),
    .result_strobe(result_strobe),
    .result       (result)
  );

  sliq_line_mem #(
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk  (clk),
    .wr_en(mem_wr),
    .rd_en(mem_rd),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

### hw/rtl/sliq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliq_checker
// Port-level checks of the serial line input queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "serial_line_input_queue_assert.svh"

module sliq_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               result_strobe,
  input sliq_pkg::result_t  result
);
  import sliq_pkg::*;

  // An accepted command makes the queue busy in the next cycle.
  `SLIQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept without busy")

  // The final result of a command shows as busy drops; earlier ones while busy.
  `SLIQ_ASSERT_IMPLIES(a_last_idle, clk, rst, result_strobe, busy != result.last,
                       "last flag out of step with busy")

  // Erase echoes run back to back.
  `SLIQ_ASSERT_NEXT(a_erase_run, clk, rst, result_strobe && !result.last,
                    result_strobe && result.kind == KIND_ECHO, "erase echo gap")

  // A read with no finished line returns zero and reports an empty queue.
  `SLIQ_ASSERT_IMPLIES(a_read_empty, clk, rst,
                       result_strobe && result.kind == KIND_READ && result.status == STATUS_EMPTY,
                       result.data == 8'd0 && result.lines_pending == 3'd0,
                       "empty read with data")

endmodule

bind serial_line_input_queue sliq_checker u_sliq_checker (.*);
